/* src/afd_pkg.sv */
package afd_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_IMPACT_LEVEL_SQ   = 3'd0,
      CSR_RECOVERY_LEVEL_SQ = 3'd1,
      CSR_IMPACT_NEEDED     = 3'd2,
      CSR_RECOVERY_NEEDED   = 3'd3,
      CSR_IMPACT_WINDOW_NS  = 3'd4,
      CSR_COOLDOWN_NS       = 3'd5
   } afd_csr_index_type;

   localparam logic [31:0] IMPACT_LEVEL_SQ_RESET   = 32'd1677721600;
   localparam logic [31:0] RECOVERY_LEVEL_SQ_RESET = 32'd355005891;
   localparam logic [1:0]  IMPACT_NEEDED_RESET     = 2'd2;
   localparam logic [1:0]  RECOVERY_NEEDED_RESET   = 2'd2;
   localparam logic [63:0] IMPACT_WINDOW_NS_RESET  = 64'd2000000000;
   localparam logic [63:0] COOLDOWN_NS_RESET       = 64'd3000000000;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [63:0]        timestamp_ns;
      logic               read_failed;
   } afd_req_type;

   typedef struct packed {
      logic        fall_detected;
      logic        sample_ok;
      logic [31:0] magnitude_sq;
   } afd_rsp_type;

   typedef struct packed {
      logic [31:0] impact_level_sq;
      logic [31:0] recovery_level_sq;
      logic [1:0]  impact_needed;
      logic [1:0]  recovery_needed;
      logic [63:0] impact_window_ns;
      logic [63:0] cooldown_ns;
   } afd_cfg_type;

   // One sample after classification against the two levels.
   typedef struct packed {
      logic        read_failed;
      logic        above_impact;
      logic        below_recovery;
      logic [31:0] magnitude_sq;
   } afd_class_type;

   // Absolute value of a raw axis; the most negative code maps to 0x8000.
   function automatic logic [15:0] axis_mag(input logic signed [15:0] raw);
      logic [15:0] v;
      v = raw;
      return v[15] ? (~v + 16'd1) : v;
   endfunction

   // A needed count of zero behaves as one.
   function automatic logic [1:0] eff_limit(input logic [1:0] needed);
      return (needed == 2'd0) ? 2'd1 : needed;
   endfunction

endpackage

/* src/afd_front.sv */
module afd_front #(
   parameter int TIME_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  afd_pkg::afd_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  afd_pkg::afd_req_type   req_data,
   output logic                   push_valid,
   input  logic                   push_ready,
   output afd_pkg::afd_class_type push_class,
   output logic [TIME_WIDTH-1:0]  push_time
);

   logic                  s1_valid_ff;
   logic                  s1_failed_ff;
   logic [31:0]           sq_x_ff;
   logic [31:0]           sq_y_ff;
   logic [31:0]           sq_z_ff;
   logic [TIME_WIDTH-1:0] time_ff;

   logic [15:0] mag_x_in;
   logic [15:0] mag_y_in;
   logic [15:0] mag_z_in;
   logic        s1_advance;
   logic [31:0] sum;

   assign s1_advance = !s1_valid_ff || push_ready;
   assign req_stall  = !s1_advance;

   assign mag_x_in = afd_pkg::axis_mag(req_data.accel_x);
   assign mag_y_in = afd_pkg::axis_mag(req_data.accel_y);
   assign mag_z_in = afd_pkg::axis_mag(req_data.accel_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && req_valid) begin
         s1_failed_ff <= req_data.read_failed;
         sq_x_ff      <= 32'(mag_x_in) * 32'(mag_x_in);
         sq_y_ff      <= 32'(mag_y_in) * 32'(mag_y_in);
         sq_z_ff      <= 32'(mag_z_in) * 32'(mag_z_in);
         time_ff      <= req_data.timestamp_ns[TIME_WIDTH-1:0];
      end
   end

   // Three squares of at most 2^30 each cannot overflow 32 bits.
   assign sum = sq_x_ff + sq_y_ff + sq_z_ff;

   always_comb begin
      push_class.read_failed    = s1_failed_ff;
      push_class.above_impact   = sum > cfg.impact_level_sq;
      push_class.below_recovery = sum < cfg.recovery_level_sq;
      push_class.magnitude_sq   = s1_failed_ff ? 32'd0 : sum;
   end

   assign push_valid = s1_valid_ff;
   assign push_time  = time_ff;

endmodule

/* src/afd_queue.sv */
module afd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]       mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   logic do_push;
   logic do_pop;

   assign push_ready = count_ff != COUNT_WIDTH'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] p);
      return (p == PTR_WIDTH'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/afd_back.sv */
module afd_back #(
   parameter int TIME_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  afd_pkg::afd_cfg_type   cfg,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  afd_pkg::afd_class_type q_class,
   input  logic [TIME_WIDTH-1:0]  q_time,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output afd_pkg::afd_rsp_type   rsp_data
);

   logic [1:0]            impact_count_ff;
   logic [1:0]            recovery_count_ff;
   logic [TIME_WIDTH-1:0] impact_start_ff;
   logic [TIME_WIDTH-1:0] last_fall_ff;
   logic                  rsp_valid_ff;
   afd_pkg::afd_rsp_type  rsp_ff;

   logic [1:0]            impact_count_in;
   logic [1:0]            recovery_count_in;
   logic [TIME_WIDTH-1:0] impact_start_in;
   logic [TIME_WIDTH-1:0] last_fall_in;
   afd_pkg::afd_rsp_type  rsp_in;

   logic [1:0]            imp_lim;
   logic [1:0]            rec_lim;
   logic [1:0]            rec_bumped;
   logic [1:0]            imp_dec;
   logic [TIME_WIDTH-1:0] since_impact;
   logic [TIME_WIDTH-1:0] since_fall;
   logic                  window_expired;
   logic                  cooldown_done;

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   assign imp_lim      = afd_pkg::eff_limit(cfg.impact_needed);
   assign rec_lim      = afd_pkg::eff_limit(cfg.recovery_needed);
   assign since_impact = q_time - impact_start_ff;
   assign since_fall   = q_time - last_fall_ff;
   assign rec_bumped   = (recovery_count_ff < rec_lim) ? recovery_count_ff + 2'd1
                                                       : recovery_count_ff;
   assign imp_dec      = impact_count_ff - 2'd1;

   assign window_expired = (impact_count_ff != 2'd0) && (impact_start_ff != '0) &&
                           (q_time >= impact_start_ff) &&
                           (64'(since_impact) > cfg.impact_window_ns);
   // A stored fall time of zero means no fall has been reported yet.
   assign cooldown_done  = (last_fall_ff == '0) ||
                           ((q_time >= last_fall_ff) &&
                            (64'(since_fall) >= cfg.cooldown_ns));

   always_comb begin
      impact_count_in      = impact_count_ff;
      recovery_count_in    = recovery_count_ff;
      impact_start_in      = impact_start_ff;
      last_fall_in         = last_fall_ff;
      rsp_in.fall_detected = 1'b0;
      rsp_in.sample_ok     = !q_class.read_failed;
      rsp_in.magnitude_sq  = q_class.magnitude_sq;

      if (q_class.read_failed) begin
         impact_count_in   = 2'd0;
         recovery_count_in = 2'd0;
         impact_start_in   = '0;
      end else if (q_class.above_impact) begin
         if (impact_count_ff == 2'd0) begin
            impact_start_in = q_time;
         end
         if (impact_count_ff < imp_lim) begin
            impact_count_in = impact_count_ff + 2'd1;
         end
         recovery_count_in = 2'd0;
      end else if (window_expired) begin
         impact_count_in   = 2'd0;
         recovery_count_in = 2'd0;
         impact_start_in   = '0;
      end else if ((impact_count_ff >= imp_lim) && q_class.below_recovery) begin
         recovery_count_in = rec_bumped;
         if ((rec_bumped >= rec_lim) && cooldown_done) begin
            rsp_in.fall_detected = 1'b1;
            last_fall_in         = q_time;
            impact_count_in      = 2'd0;
            recovery_count_in    = 2'd0;
            impact_start_in      = '0;
         end
      end else if (!q_class.below_recovery) begin
         recovery_count_in = 2'd0;
         if (impact_count_ff != 2'd0) begin
            impact_count_in = imp_dec;
            if (imp_dec == 2'd0) begin
               impact_start_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         impact_count_ff   <= 2'd0;
         recovery_count_ff <= 2'd0;
         impact_start_ff   <= '0;
         last_fall_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (q_pop) begin
            impact_count_ff   <= impact_count_in;
            recovery_count_ff <= recovery_count_in;
            impact_start_ff   <= impact_start_in;
            last_fall_ff      <= last_fall_in;
            rsp_valid_ff      <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/accel_fall_detector.sv */
// Channel  | Ports                                  | Transfer when
// ---------+----------------------------------------+------------------------
// request  | req_valid, req_stall, req_data         | req_valid && !req_stall
// response | rsp_valid, rsp_stall, rsp_data         | rsp_valid && !rsp_stall
// csr      | csr_valid, csr_ready, csr_index/wdata  | csr_valid && csr_ready
//
// One sample per cycle sustained while rsp_stall is low; a request passes the square
// stage, a queue entry and the detector state update into the response register.
// The detector state feeds back on itself, which sets the one-per-cycle rate.
// Reset is synchronous: counters, pending impact and last fall time clear, the
// registers return to their defaults and no response is valid.
// A stalled response backs up into the queue; requests stall only once it is full.
// csr writes are always taken and must only happen while the block is idle.
module accel_fall_detector #(
   parameter int TIME_WIDTH  = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  afd_pkg::afd_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output afd_pkg::afd_rsp_type                  rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [afd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [afd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int CLASS_WIDTH = $bits(afd_pkg::afd_class_type);
   localparam int ENTRY_WIDTH = CLASS_WIDTH + TIME_WIDTH;

   afd_pkg::afd_cfg_type   cfg_ff;
   afd_pkg::afd_class_type push_class;
   afd_pkg::afd_class_type pop_class;
   logic [TIME_WIDTH-1:0]  push_time;
   logic [TIME_WIDTH-1:0]  pop_time;
   logic                   push_valid;
   logic                   push_ready;
   logic                   pop_valid;
   logic                   pop_ready;
   logic [ENTRY_WIDTH-1:0] pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.impact_level_sq   <= afd_pkg::IMPACT_LEVEL_SQ_RESET;
         cfg_ff.recovery_level_sq <= afd_pkg::RECOVERY_LEVEL_SQ_RESET;
         cfg_ff.impact_needed     <= afd_pkg::IMPACT_NEEDED_RESET;
         cfg_ff.recovery_needed   <= afd_pkg::RECOVERY_NEEDED_RESET;
         cfg_ff.impact_window_ns  <= afd_pkg::IMPACT_WINDOW_NS_RESET;
         cfg_ff.cooldown_ns       <= afd_pkg::COOLDOWN_NS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (afd_pkg::afd_csr_index_type'(csr_index))
            afd_pkg::CSR_IMPACT_LEVEL_SQ: begin
               cfg_ff.impact_level_sq <= csr_wdata[31:0];
            end
            afd_pkg::CSR_RECOVERY_LEVEL_SQ: begin
               cfg_ff.recovery_level_sq <= csr_wdata[31:0];
            end
            afd_pkg::CSR_IMPACT_NEEDED: begin
               cfg_ff.impact_needed <= csr_wdata[1:0];
            end
            afd_pkg::CSR_RECOVERY_NEEDED: begin
               cfg_ff.recovery_needed <= csr_wdata[1:0];
            end
            afd_pkg::CSR_IMPACT_WINDOW_NS: begin
               cfg_ff.impact_window_ns <= csr_wdata;
            end
            afd_pkg::CSR_COOLDOWN_NS: begin
               cfg_ff.cooldown_ns <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   afd_front #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_class (push_class),
      .push_time  (push_time)
   );

   afd_queue #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_class, push_time}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   assign pop_class = pop_entry[ENTRY_WIDTH-1:TIME_WIDTH];
   assign pop_time  = pop_entry[TIME_WIDTH-1:0];

   afd_back #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (pop_valid),
      .q_pop     (pop_ready),
      .q_class   (pop_class),
      .q_time    (pop_time),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A fall can only be reported on a sample that was read.
   a_fall_needs_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.fall_detected || rsp_data.sample_ok))
      else $error("fall reported on a failed read");

   // A failed read reports nothing but zeros.
   a_failed_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.sample_ok) |-> (rsp_data.magnitude_sq == 32'd0))
      else $error("failed read carries a magnitude");

   // The front end keeps its sample while the queue is full.
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |=> push_valid)
      else $error("front end dropped a sample while the queue was full");

   // Right after reset nothing is in flight and requests are taken.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall && !pop_valid))
      else $error("pipeline not empty after reset");

endmodule
